>>> hw/rtl/bit_matrix_adjacency_store_top_macros.svh
// assertion macros for the adjacency store checker
// no dependencies; included by the checker file
`ifndef BIT_MATRIX_ADJACENCY_STORE_TOP_MACROS_SVH
`define BIT_MATRIX_ADJACENCY_STORE_TOP_MACROS_SVH

// property that must hold in the same cycle, disabled in reset
`define BMAS_ASSERT_NOW(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// implication checked in the next cycle, disabled in reset
`define BMAS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bmas_pkg.sv
// shared types, codes and helpers for the adjacency bit matrix store
// no dependencies
`default_nettype none

package bmas_pkg;

  localparam int WORD_BITS = 64;
  localparam int POS_W     = 6;
  localparam int WIDX_W    = 2;
  localparam int CNT_W     = 9;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;

  // operation codes
  localparam logic [2:0] FN_SET        = 3'd0;
  localparam logic [2:0] FN_CLEAR      = 3'd1;
  localparam logic [2:0] FN_TEST       = 3'd2;
  localparam logic [2:0] FN_COUNT      = 3'd3;
  localparam logic [2:0] FN_WALK_START = 3'd4;
  localparam logic [2:0] FN_WALK_NEXT  = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_DATA,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // status of the highest-bit search unit
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
  } hsb_stat_t;

  // highest set bit of an 8-bit group
  function automatic logic [2:0] enc8(logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // highest set bit of a 16-bit group
  function automatic logic [3:0] enc16(logic [15:0] v);
    logic [3:0] r;
    if (v[15:8] != 8'd0) r = {1'b1, enc8(v[15:8])};
    else r = {1'b0, enc8(v[7:0])};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bmas_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module bmas_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmas_hsb.sv
// iterative highest-set-bit search over a 64-bit word, 16 bits a cycle
// depends on bmas_pkg
`default_nettype none

module bmas_hsb (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [bmas_pkg::WORD_BITS-1:0]     word,
  output bmas_pkg::hsb_stat_t                     stat
);
  import bmas_pkg::*;

  logic                 busy;
  logic [1:0]           grp;
  logic [WORD_BITS-1:0] w;
  logic [15:0]          sel;

  // current 16-bit group, scanned from the top
  assign sel = w[{grp, 4'b0000} +: 16];

  assign stat.done = busy && (sel != 16'd0);
  assign stat.pos  = {grp, enc16(sel)};

  // search control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      grp  <= 2'd3;
    end else if (start) begin
      busy <= 1'b1;
      grp  <= 2'd3;
    end else if (busy) begin
      if (sel != 16'd0) busy <= 1'b0;
      else grp <= grp - 2'd1;
    end
  end

  // word under search
  always_ff @(posedge clk) begin
    if (start) w <= word;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bit_matrix_adjacency_store_top.sv
// adjacency bit matrix store: sequencer, edge word ram, row count ram, bit search
// depends on bmas_pkg, bmas_ram, bmas_hsb
// set, clear, test, count, walk start: LOOK, DATA (ram read + write) and FINISH from accept to ready,
//   LOOK and FINISH only when row (or col for set, clear, test) is out of range and for unused codes
// walk next: LOOK and FINISH when exhausted; with a bit in the held word, LOOK, SCAN (search
//   unit, 16 bits a cycle) and FINISH; each further word fetched from the ram adds READ, DATA and LOOK
// one item at a time; the result register lets the next item in while a result waits
// reset: synchronous, then a clearing pass over all rows*words edge words (1024 by default) and row counts
`default_nettype none

module bit_matrix_adjacency_store_top #(
  parameter int NODES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // s_tdata: func[2:0], row[10:3], col[18:11], zero fill
  input  wire logic [bmas_pkg::IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // m_tdata: bit_value[0], neighbour_count[9:1], neighbour[17:10], exhausted[18], zero fill
  output logic      [bmas_pkg::OUT_W-1:0] m_tdata
);
  import bmas_pkg::*;

  localparam int ROWS      = (NODES < 256) ? NODES : 256;
  localparam int WORDS_ALL = (NODES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORDS     = (WORDS_ALL < 4) ? WORDS_ALL : 4;
  localparam int EDEPTH    = ROWS * WORDS;
  localparam int EA_W      = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int CA_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [12:0] NODES_L = 13'(NODES);

  // ram address of word w of row r
  function automatic logic [EA_W-1:0] word_addr(logic [7:0] r, logic [1:0] w);
    logic [9:0] a;
    a = 10'(r) * 10'(WORDS) + 10'(w);
    return a[EA_W-1:0];
  endfunction

  state_t state, state_next;

  logic [2:0]           in_func;
  logic [7:0]           in_row;
  logic [7:0]           in_col;
  logic [EA_W-1:0]      ea;
  logic [CA_W-1:0]      ca;
  logic [EA_W-1:0]      clr;

  logic [7:0]           walk_row;
  logic [WIDX_W-1:0]    walk_idx;
  logic [WORD_BITS-1:0] walk_word;
  logic [CNT_W-1:0]     walk_left;

  logic                 res_bit;
  logic [CNT_W-1:0]     res_cnt;
  logic [7:0]           res_nb;
  logic                 res_exh;

  logic                 e_we, c_we;
  logic [EA_W-1:0]      e_addr;
  logic [CA_W-1:0]      c_addr;
  logic [WORD_BITS-1:0] e_wdata, e_rdata;
  logic [CNT_W-1:0]     c_wdata, c_rdata;

  logic                 hsb_start;
  hsb_stat_t            hsb_stat;

  logic                 row_ok, col_ok, wrow_ok;
  logic                 walk_go, last_word, hit, out_free, clr_done;
  logic [WORD_BITS-1:0] mask;

  // decode helpers
  assign row_ok    = {5'b00000, in_row} < NODES_L;
  assign col_ok    = {5'b00000, in_col} < NODES_L;
  assign wrow_ok   = {5'b00000, walk_row} < NODES_L;
  assign walk_go   = (walk_left != '0) && wrow_ok;
  assign last_word = ({1'b0, walk_idx} + 3'd1) >= 3'(WORDS);
  assign mask      = WORD_BITS'(1) << in_col[POS_W-1:0];
  assign hit       = e_rdata[in_col[POS_W-1:0]];
  assign out_free  = !m_tvalid || m_tready;
  assign clr_done  = clr == EA_W'(EDEPTH - 1);

  // edge word store
  bmas_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(EDEPTH)
  ) u_edge_ram (
    .clk  (clk),
    .we   (e_we),
    .addr (e_addr),
    .wdata(e_wdata),
    .rdata(e_rdata)
  );

  // per-row set-bit counts
  bmas_ram #(
    .WIDTH(CNT_W),
    .DEPTH(ROWS)
  ) u_count_ram (
    .clk  (clk),
    .we   (c_we),
    .addr (c_addr),
    .wdata(c_wdata),
    .rdata(c_rdata)
  );

  // highest-bit search for walk next
  bmas_hsb u_hsb (
    .clk  (clk),
    .rst  (rst),
    .start(hsb_start),
    .word (walk_word),
    .stat (hsb_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        unique case (in_func)
          FN_SET, FN_CLEAR, FN_TEST: begin
            state_next = (row_ok && col_ok) ? ST_DATA : ST_FINISH;
          end
          FN_COUNT, FN_WALK_START: begin
            state_next = row_ok ? ST_DATA : ST_FINISH;
          end
          FN_WALK_NEXT: begin
            if (!walk_go) state_next = ST_FINISH;
            else if (walk_word != '0) state_next = ST_SCAN;
            else if (last_word) state_next = ST_FINISH;
            else state_next = ST_READ;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_READ: state_next = ST_DATA;
      ST_DATA: begin
        state_next = (in_func == FN_WALK_NEXT) ? ST_LOOK : ST_FINISH;
      end
      ST_SCAN: begin
        if (hsb_stat.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // ram ports, search start and input ready
  always_comb begin
    s_tready  = (state == ST_IDLE);
    e_we      = 1'b0;
    e_addr    = ea;
    e_wdata   = e_rdata;
    c_we      = 1'b0;
    c_addr    = ca;
    c_wdata   = c_rdata;
    hsb_start = (state == ST_LOOK) && (in_func == FN_WALK_NEXT) && walk_go
                && (walk_word != '0);
    unique case (state)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_addr  = clr;
        e_wdata = '0;
        c_we    = 11'(clr) < 11'(ROWS);
        c_addr  = clr[CA_W-1:0];
        c_wdata = '0;
      end
      ST_DATA: begin
        if (in_func == FN_SET && !hit) begin
          e_we    = 1'b1;
          e_wdata = e_rdata | mask;
          c_we    = 1'b1;
          c_wdata = c_rdata + CNT_W'(1);
        end else if (in_func == FN_CLEAR && hit) begin
          e_we    = 1'b1;
          e_wdata = e_rdata & ~mask;
          c_we    = 1'b1;
          c_wdata = c_rdata - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control state, walk registers and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      m_tvalid  <= 1'b0;
      walk_row  <= '0;
      walk_idx  <= '0;
      walk_word <= '0;
      walk_left <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + EA_W'(1);
      if (state == ST_FINISH && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_LOOK: begin
          if (in_func == FN_WALK_START && !row_ok) begin
            walk_row  <= in_row;
            walk_idx  <= '0;
            walk_word <= '0;
            walk_left <= '0;
          end else if (in_func == FN_WALK_NEXT) begin
            if (!walk_go || (walk_word == '0 && last_word)) walk_left <= '0;
            else if (walk_word == '0) walk_idx <= walk_idx + WIDX_W'(1);
          end
        end
        ST_DATA: begin
          if (in_func == FN_WALK_START) begin
            walk_row  <= in_row;
            walk_idx  <= '0;
            walk_word <= e_rdata;
            walk_left <= c_rdata;
          end else if (in_func == FN_WALK_NEXT) begin
            walk_word <= e_rdata;
          end
        end
        ST_SCAN: begin
          if (hsb_stat.done) begin
            walk_word[hsb_stat.pos] <= 1'b0;
            walk_left               <= walk_left - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // item capture, addresses and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_func <= s_tdata[2:0];
          in_row  <= s_tdata[10:3];
          in_col  <= s_tdata[18:11];
          ea      <= word_addr(s_tdata[10:3],
                               (s_tdata[2:0] == FN_WALK_START) ? 2'd0 : s_tdata[18:17]);
          ca      <= s_tdata[3 +: CA_W];
          res_bit <= 1'b0;
          res_cnt <= '0;
          res_nb  <= '0;
          res_exh <= 1'b0;
        end
      end
      ST_LOOK: begin
        if (in_func == FN_WALK_NEXT) begin
          if (!walk_go || (walk_word == '0 && last_word)) res_exh <= 1'b1;
          else if (walk_word == '0) ea <= word_addr(walk_row, walk_idx + WIDX_W'(1));
        end
      end
      ST_DATA: begin
        if (in_func == FN_TEST) res_bit <= hit;
        if (in_func == FN_COUNT) res_cnt <= c_rdata;
      end
      ST_SCAN: begin
        if (hsb_stat.done) res_nb <= {walk_idx, hsb_stat.pos};
      end
      ST_FINISH: begin
        if (out_free) m_tdata <= {5'b00000, res_exh, res_nb, res_cnt, res_bit};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmas_checker.sv
// port-level checks for the adjacency store, bound to the top level
// depends on bmas_pkg and bit_matrix_adjacency_store_top_macros.svh
`default_nettype none
`include "bit_matrix_adjacency_store_top_macros.svh"

module bmas_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [bmas_pkg::OUT_W-1:0] m_tdata
);
  import bmas_pkg::*;

  logic [3:0] flags;

  // result fields that carry an answer
  assign flags = {m_tdata[0], m_tdata[9:1] != 9'd0, m_tdata[17:10] != 8'd0, m_tdata[18]};

  // one item in work at a time
  `BMAS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted while busy")

  // a stalled result holds
  `BMAS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

  // fill bits stay zero
  `BMAS_ASSERT_NOW(a_out_fill, clk, rst, !m_tvalid || (m_tdata[OUT_W-1:19] == '0), "fill bits set")

  // each result answers at most one operation
  `BMAS_ASSERT_NOW(a_one_answer, clk, rst, !m_tvalid || ($countones(flags) <= 1), "mixed result fields")

endmodule

bind bit_matrix_adjacency_store_top bmas_checker u_bmas_checker (.*);

`default_nettype wire
